/* rtl/slotted_page_space_manager_unit_defines.svh */
// ----------------------------------------------------------------------------
// Slotted page space manager - assertion macros
// Concurrent assertion wrappers, removed when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SLOTTED_PAGE_SPACE_MANAGER_UNIT_DEFINES_SVH
`define SLOTTED_PAGE_SPACE_MANAGER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPSM_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SPSM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SPSM_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define SPSM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/spsm_pkg.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager - package
// Page geometry, field widths, codes and shared types.
// ----------------------------------------------------------------------------
package spsm_pkg;

   localparam int unsigned PageBytes   = 4096;
   localparam int unsigned MaxSlots    = 64;
   localparam int unsigned HeaderBytes = 32;
   localparam int unsigned SlotBytes   = 8;

   localparam int unsigned LenW       = 13;
   localparam int unsigned SlotW      = 6;
   localparam int unsigned CountW     = 7;
   localparam int unsigned StatusW    = 2;
   localparam int unsigned GroupW     = 8;
   localparam int unsigned GroupCount = MaxSlots / GroupW;
   localparam int unsigned GroupIdxW  = $clog2(GroupCount);
   localparam int unsigned BitIdxW    = $clog2(GroupW);

   localparam logic [LenW-1:0]   FREE_RESET = LenW'(PageBytes - HeaderBytes - SlotBytes);
   localparam logic [LenW-1:0]   DATA_RESET = LenW'(PageBytes);
   localparam logic [LenW-1:0]   LEN_MAX    = {LenW{1'b1}};
   localparam logic [CountW-1:0] SLOTS_ALL  = CountW'(MaxSlots);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_DIR_FULL   = 2'd2,
      STATUS_EMPTY_SLOT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [SlotW-1:0]     rd_slot;
      logic                 wr_en;
      logic [SlotW-1:0]     wr_slot;
      logic [LenW-1:0]      wr_len;
      logic                 clr_en;
      logic [SlotW-1:0]     clr_slot;
      logic                 scan_start;
      logic [GroupIdxW-1:0] scan_group;
   } dir_cmd_type;

   typedef struct packed {
      logic              rd_used;
      logic [LenW-1:0]   rd_len;
      logic              scan_done;
      logic [CountW-1:0] scan_next;
   } dir_stat_type;

   function automatic logic [LenW-1:0] dir_end_bytes(input logic [CountW-1:0] n);
      dir_end_bytes = LenW'(HeaderBytes) + LenW'(n) * LenW'(SlotBytes);
   endfunction

endpackage

/* rtl/spsm_req_if.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager - request channel
// Valid/ready channel carrying one page operation.
// ----------------------------------------------------------------------------
interface spsm_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [spsm_pkg::LenW-1:0]  record_length;
   logic [spsm_pkg::SlotW-1:0] slot_index;

   modport source (output valid, op, record_length, slot_index, input ready);
   modport sink   (input valid, op, record_length, slot_index, output ready);
endinterface

/* rtl/spsm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager - response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface spsm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [spsm_pkg::StatusW-1:0] status;
   logic [spsm_pkg::SlotW-1:0]   slot_number;
   logic [spsm_pkg::LenW-1:0]    free_bytes;

   modport source (output valid, status, slot_number, free_bytes, input ready);
   modport sink   (input valid, status, slot_number, free_bytes, output ready);
endinterface

/* rtl/slotted_page_space_manager_unit.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager
// Slot directory and free space bookkeeping of one slotted database page.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    op, record_length, slot_index
//   rsp_chan  out  valid/ready    status, slot_number, free_bytes
//
// One operation at a time. Refused inserts and all removes go from the execute
// state straight to the done state; a successful insert adds a free slot
// scan, one 8-slot group of used bits per cycle from the taken slot's group
// upward, until a group with a free slot or the last group is reached.
// A waiting result sits in the response register while the next request
// is taken; a stalled response holds completion of the following one.
// ----------------------------------------------------------------------------
`include "slotted_page_space_manager_unit_defines.svh"

module slotted_page_space_manager_unit (
   input logic        clock,
   input logic        reset,
   spsm_req_if.sink   req_chan,
   spsm_rsp_if.source rsp_chan
);

   spsm_pkg::state_type    state_ff, state_in;
   spsm_pkg::dir_cmd_type  dir_cmd;
   spsm_pkg::dir_stat_type dir_stat;

   logic                          req_accept;
   logic                          op_ff;
   logic [spsm_pkg::LenW-1:0]     len_ff;
   logic [spsm_pkg::SlotW-1:0]    idx_ff;

   logic [spsm_pkg::CountW-1:0]   first_free_ff, first_free_in;
   logic [spsm_pkg::CountW-1:0]   record_count_ff, record_count_in;
   logic [spsm_pkg::CountW-1:0]   directory_slots_ff, directory_slots_in;
   logic [spsm_pkg::LenW-1:0]     free_space_ff, free_space_in;
   logic [spsm_pkg::LenW-1:0]     data_start_ff, data_start_in;

   spsm_pkg::status_type          res_status_ff, res_status_in;
   logic [spsm_pkg::SlotW-1:0]    res_slot_ff, res_slot_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spsm_pkg::StatusW-1:0]  rsp_status_ff;
   logic [spsm_pkg::SlotW-1:0]    rsp_slot_ff;
   logic [spsm_pkg::LenW-1:0]     rsp_free_ff;

   logic [spsm_pkg::CountW-1:0]   new_dir;
   logic [spsm_pkg::LenW-1:0]     dir_end;
   logic [spsm_pkg::LenW-1:0]     gap;
   logic [spsm_pkg::LenW:0]       free_sum;
   logic                          ins_short, ins_full, gap_short, ins_ok, rem_ok;
   logic                          rsp_load;

   spsm_slot_dir u_dir (
      .clock (clock),
      .reset (reset),
      .cmd   (dir_cmd),
      .stat  (dir_stat)
   );

   assign req_chan.ready = (state_ff == spsm_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign new_dir   = (first_free_ff >= directory_slots_ff) ? first_free_ff + 1'b1
                                                           : directory_slots_ff;
   assign dir_end   = spsm_pkg::dir_end_bytes(new_dir);
   assign gap       = (data_start_ff > dir_end) ? data_start_ff - dir_end : '0;
   assign ins_short = len_ff > free_space_ff;
   assign ins_full  = first_free_ff >= spsm_pkg::SLOTS_ALL;
   assign gap_short = gap < len_ff;
   assign ins_ok    = !ins_short && !ins_full && !gap_short;
   assign rem_ok    = dir_stat.rd_used;
   assign free_sum  = {1'b0, free_space_ff} + {1'b0, dir_stat.rd_len};
   assign rsp_load  = (state_ff == spsm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spsm_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = spsm_pkg::ST_EXEC;
            end
         end
         spsm_pkg::ST_EXEC: begin
            if (op_ff == spsm_pkg::OP_INSERT && ins_ok) begin
               state_in = spsm_pkg::ST_SCAN;
            end else begin
               state_in = spsm_pkg::ST_DONE;
            end
         end
         spsm_pkg::ST_SCAN: begin
            if (dir_stat.scan_done) begin
               state_in = spsm_pkg::ST_DONE;
            end
         end
         spsm_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = spsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spsm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and state updates
   always_comb begin
      dir_cmd            = '0;
      dir_cmd.rd_en      = req_accept;
      dir_cmd.rd_slot    = req_chan.slot_index;
      first_free_in      = first_free_ff;
      record_count_in    = record_count_ff;
      directory_slots_in = directory_slots_ff;
      free_space_in      = free_space_ff;
      data_start_in      = data_start_ff;
      res_status_in      = res_status_ff;
      res_slot_in        = res_slot_ff;
      case (state_ff)
         spsm_pkg::ST_EXEC: begin
            res_slot_in = '0;
            if (op_ff == spsm_pkg::OP_INSERT) begin
               if (ins_short || (!ins_full && gap_short)) begin
                  res_status_in = spsm_pkg::STATUS_NO_SPACE;
               end else if (ins_full) begin
                  res_status_in = spsm_pkg::STATUS_DIR_FULL;
               end else begin
                  res_status_in      = spsm_pkg::STATUS_OK;
                  res_slot_in        = first_free_ff[spsm_pkg::SlotW-1:0];
                  dir_cmd.wr_en      = 1'b1;
                  dir_cmd.wr_slot    = first_free_ff[spsm_pkg::SlotW-1:0];
                  dir_cmd.wr_len     = len_ff;
                  dir_cmd.scan_start = 1'b1;
                  dir_cmd.scan_group =
                     first_free_ff[spsm_pkg::SlotW-1:spsm_pkg::BitIdxW];
                  data_start_in      = data_start_ff - len_ff;
                  free_space_in      = free_space_ff - len_ff;
                  record_count_in    = record_count_ff + 1'b1;
                  directory_slots_in = new_dir;
               end
            end else if (rem_ok) begin
               res_status_in    = spsm_pkg::STATUS_OK;
               dir_cmd.clr_en   = 1'b1;
               dir_cmd.clr_slot = idx_ff;
               free_space_in    = free_sum[spsm_pkg::LenW] ? spsm_pkg::LEN_MAX
                                                           : free_sum[spsm_pkg::LenW-1:0];
               record_count_in  = record_count_ff - 1'b1;
               if (spsm_pkg::CountW'(idx_ff) < first_free_ff) begin
                  first_free_in = spsm_pkg::CountW'(idx_ff);
               end
            end else begin
               res_status_in = spsm_pkg::STATUS_EMPTY_SLOT;
            end
         end
         spsm_pkg::ST_SCAN: begin
            if (dir_stat.scan_done) begin
               first_free_in = dir_stat.scan_next;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= spsm_pkg::ST_IDLE;
         first_free_ff      <= '0;
         record_count_ff    <= '0;
         directory_slots_ff <= '0;
         free_space_ff      <= spsm_pkg::FREE_RESET;
         data_start_ff      <= spsm_pkg::DATA_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         first_free_ff      <= first_free_in;
         record_count_ff    <= record_count_in;
         directory_slots_ff <= directory_slots_in;
         free_space_ff      <= free_space_in;
         data_start_ff      <= data_start_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_chan.op;
         len_ff <= req_chan.record_length;
         idx_ff <= req_chan.slot_index;
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_free_ff   <= free_space_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.slot_number = rsp_slot_ff;
   assign rsp_chan.free_bytes  = rsp_free_ff;

   `SPSM_ASSERT_ALWAYS(a_free_bound, clock, reset,
      free_space_ff <= spsm_pkg::FREE_RESET, "free space above page capacity")
   `SPSM_ASSERT_ALWAYS(a_first_free_in_dir, clock, reset,
      first_free_ff <= directory_slots_ff, "first free slot beyond directory")
   `SPSM_ASSERT_ALWAYS(a_count_in_dir, clock, reset,
      record_count_ff <= directory_slots_ff, "record count beyond directory")
   `SPSM_ASSERT_IMPLIES(a_data_above_dir, clock, reset, state_ff == spsm_pkg::ST_IDLE,
      data_start_ff >= spsm_pkg::dir_end_bytes(directory_slots_ff),
      "record data overlaps directory")

endmodule

/* rtl/spsm_slot_dir.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager - slot directory
// Slot used bits, record length memory and the group-wise free slot scan.
// ----------------------------------------------------------------------------
module spsm_slot_dir (
   input  logic                   clock,
   input  logic                   reset,
   input  spsm_pkg::dir_cmd_type  cmd,
   output spsm_pkg::dir_stat_type stat
);

   localparam int unsigned GW = spsm_pkg::GroupW;

   logic [spsm_pkg::MaxSlots-1:0]  used_ff, used_in;
   logic [spsm_pkg::LenW-1:0]      len_mem [spsm_pkg::MaxSlots];
   logic [spsm_pkg::LenW-1:0]      rd_len_ff;
   logic                           rd_used_ff;
   logic                           scan_busy_ff, scan_busy_in;
   logic [spsm_pkg::GroupIdxW-1:0] scan_group_ff, scan_group_in;
   logic [GW-1:0]                  group_bits;
   logic [spsm_pkg::BitIdxW-1:0]   first_zero;
   logic                           group_hit;
   logic                           scan_last;

   always_comb begin
      used_in = used_ff;
      if (cmd.wr_en) begin
         used_in[cmd.wr_slot] = 1'b1;
      end
      if (cmd.clr_en) begin
         used_in[cmd.clr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         len_mem[cmd.wr_slot] <= cmd.wr_len;
      end
      if (cmd.rd_en) begin
         rd_len_ff  <= len_mem[cmd.rd_slot];
         rd_used_ff <= used_ff[cmd.rd_slot];
      end
   end

   assign group_bits = used_ff[{scan_group_ff, {spsm_pkg::BitIdxW{1'b0}}} +: GW];
   assign group_hit  = ~&group_bits;
   assign scan_last  = (scan_group_ff == spsm_pkg::GroupIdxW'(spsm_pkg::GroupCount - 1));

   always_comb begin
      first_zero = '0;
      for (int i = GW - 1; i >= 0; i--) begin
         if (!group_bits[i]) begin
            first_zero = spsm_pkg::BitIdxW'(i);
         end
      end
   end

   always_comb begin
      scan_busy_in  = scan_busy_ff;
      scan_group_in = scan_group_ff;
      if (cmd.scan_start) begin
         scan_busy_in  = 1'b1;
         scan_group_in = cmd.scan_group;
      end else if (scan_busy_ff) begin
         if (group_hit || scan_last) begin
            scan_busy_in = 1'b0;
         end else begin
            scan_group_in = scan_group_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff  <= 1'b0;
         scan_group_ff <= '0;
      end else begin
         scan_busy_ff  <= scan_busy_in;
         scan_group_ff <= scan_group_in;
      end
   end

   always_comb begin
      stat.rd_used   = rd_used_ff;
      stat.rd_len    = rd_len_ff;
      stat.scan_done = scan_busy_ff && (group_hit || scan_last);
      stat.scan_next = group_hit ? spsm_pkg::CountW'({scan_group_ff, first_zero})
                                 : spsm_pkg::SLOTS_ALL;
   end

endmodule

/* tb/slotted_page_space_manager_unit_checker.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager - checker
// Watches both channels. It predicts each operation's result from its own
// copy of the page state, queues the result, and compares every response
// transfer field by field with the oldest queued result. It reports the
// failure count, the number of results still awaited and a tally per status.
// ----------------------------------------------------------------------------
module slotted_page_space_manager_unit_checker
   import spsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   spsm_req_if               req_mon,
   spsm_rsp_if               rsp_mon,
   output int unsigned       error_count,
   output int unsigned       in_flight,
   output logic [3:0][31:0]  status_tally
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type        status;
      logic [SlotW-1:0]  slot;
      logic [LenW-1:0]   free;
   } page_reply_t;

   page_reply_t awaited_replies[$];

   logic        slot_taken [MaxSlots];
   int unsigned record_bytes [MaxSlots];
   int unsigned lowest_free;
   int unsigned free_total;
   int unsigned data_floor;
   int unsigned dir_high;
   int unsigned fails;

   function automatic page_reply_t page_outcome(input op_type op, input int unsigned len,
                                                input int unsigned idx);
      page_reply_t reply;
      int unsigned grown_dir;
      int unsigned dir_top;
      int unsigned gap;
      int unsigned k;
      reply.status = STATUS_OK;
      reply.slot   = '0;
      if (op == OP_INSERT) begin
         if (len > free_total) begin
            reply.status = STATUS_NO_SPACE;
         end else if (lowest_free >= MaxSlots) begin
            reply.status = STATUS_DIR_FULL;
         end else begin
            grown_dir = (lowest_free >= dir_high) ? lowest_free + 1 : dir_high;
            dir_top   = HeaderBytes + grown_dir * SlotBytes;
            gap       = (data_floor > dir_top) ? data_floor - dir_top : 0;
            if (gap < len) begin
               reply.status = STATUS_NO_SPACE;
            end else begin
               data_floor -= len;
               free_total -= len;
               slot_taken[lowest_free]   = 1'b1;
               record_bytes[lowest_free] = len;
               dir_high   = grown_dir;
               reply.slot = SlotW'(lowest_free);
               k = lowest_free + 1;
               while (k < MaxSlots && slot_taken[k]) k++;
               lowest_free = k;
            end
         end
      end else if (!slot_taken[idx]) begin
         reply.status = STATUS_EMPTY_SLOT;
      end else begin
         free_total += record_bytes[idx];
         if (free_total > LEN_MAX) free_total = LEN_MAX;
         slot_taken[idx] = 1'b0;
         if (idx < lowest_free) lowest_free = idx;
      end
      reply.free = LenW'(free_total);
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      page_reply_t want;
      if (reset) begin
         awaited_replies.delete();
         for (int i = 0; i < MaxSlots; i++) begin
            slot_taken[i]   = 1'b0;
            record_bytes[i] = 0;
         end
         lowest_free = 0;
         free_total  = PageBytes - HeaderBytes - SlotBytes;
         data_floor  = PageBytes;
         dir_high    = 0;
         fails       = 0;
         status_tally <= '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_replies.size() == 0) begin
               $error("response transfer with no result awaited: status %0d slot %0d free %0d",
                      rsp_mon.status, rsp_mon.slot_number, rsp_mon.free_bytes);
               fails++;
            end else begin
               want = awaited_replies.pop_front();
               status_tally[want.status] <= status_tally[want.status] + 1;
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  fails++;
               end
               if (rsp_mon.slot_number !== want.slot) begin
                  $error("slot_number mismatch: expected %0d, actual %0d",
                         want.slot, rsp_mon.slot_number);
                  fails++;
               end
               if (rsp_mon.free_bytes !== want.free) begin
                  $error("free_bytes mismatch: expected %0d, actual %0d",
                         want.free, rsp_mon.free_bytes);
                  fails++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_replies.push_back(page_outcome(op_type'(req_mon.op),
                                                   req_mon.record_length,
                                                   req_mon.slot_index));
         end
      end
      in_flight   <= awaited_replies.size();
      error_count <= fails;
   end

endmodule

/* tb/slotted_page_space_manager_unit_tb.sv */
// ----------------------------------------------------------------------------
// Slotted page space manager - testbench top
// Drives page operations into the block: a directed opening over the space,
// directory and empty-slot cases, then phases of insert-heavy and
// remove-heavy random traffic with random gaps and stalls on both sides,
// one long response stall and one full drain. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module slotted_page_space_manager_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spsm_pkg::*;

   localparam int unsigned RandomOps  = 1950;
   localparam int unsigned CycleLimit = 400000;

   logic        clock;
   logic        reset;
   int unsigned error_count;
   int unsigned in_flight;
   logic [3:0][31:0] status_tally;
   logic        no_gaps;

   spsm_req_if req_chan_if ();
   spsm_rsp_if rsp_chan_if ();

   slotted_page_space_manager_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_if),
      .rsp_chan (rsp_chan_if)
   );

   slotted_page_space_manager_unit_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan_if),
      .rsp_mon      (rsp_chan_if),
      .error_count  (error_count),
      .in_flight    (in_flight),
      .status_tally (status_tally)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("slotted_page_space_manager_unit verification failed");
            $finish;
         end
      end
   end

   // After response transfers, hold ready low for a drawn, zero or long stall.
   initial begin : drain
      int unsigned stall;
      int unsigned taken;
      rsp_chan_if.ready = 1'b0;
      stall = 0;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         rsp_chan_if.ready = (stall == 0);
         @(posedge clock);
         if (rsp_chan_if.valid && rsp_chan_if.ready) begin
            taken++;
            if (taken == 600) begin
               stall = 300;
            end else if ((taken / 200) % 4 == 1) begin
               stall = 0;
            end else begin
               stall = $urandom_range(0, 9);
            end
         end else if (stall > 0) begin
            stall--;
         end
         @(negedge clock);
      end
   end

   task automatic send_op(input op_type op, input logic [LenW-1:0] len,
                          input logic [SlotW-1:0] idx);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan_if.op            = op;
      req_chan_if.record_length = len;
      req_chan_if.slot_index    = idx;
      req_chan_if.valid         = 1'b1;
      do @(posedge clock); while (!req_chan_if.ready);
      @(negedge clock);
   endtask

   function automatic logic [LenW-1:0] draw_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return '0;
      if (pick < 90) return LenW'($urandom_range(1, 4));
      if (pick < 98) return LenW'($urandom_range(5, 48));
      return LenW'($urandom_range(0, PageBytes));
   endfunction

   initial begin : stimulus
      int unsigned phase;
      int unsigned insert_share;
      req_chan_if.valid         = 1'b0;
      req_chan_if.op            = OP_INSERT;
      req_chan_if.record_length = '0;
      req_chan_if.slot_index    = '0;
      no_gaps = 1'b0;
      reset   = 1'b1;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      send_op(OP_REMOVE, '0, 6'd0);
      send_op(OP_REMOVE, '0, 6'd63);
      send_op(OP_INSERT, LenW'(PageBytes), '0);
      send_op(OP_INSERT, LenW'(PageBytes - 1), 6'd63);
      send_op(OP_INSERT, '0, '0);
      send_op(OP_INSERT, '0, '0);
      send_op(OP_INSERT, '0, '0);
      // total space suffices, the gap below the grown directory does not
      send_op(OP_INSERT, LenW'(PageBytes - HeaderBytes - SlotBytes), '0);
      send_op(OP_INSERT, LenW'(1), '0);
      send_op(OP_REMOVE, LenW'(PageBytes), 6'd1);
      send_op(OP_REMOVE, '0, 6'd1);
      send_op(OP_INSERT, LenW'(2), '0);
      send_op(OP_REMOVE, '0, 6'd3);
      send_op(OP_REMOVE, '0, 6'd0);
      send_op(OP_INSERT, '0, 6'd42);
      send_op(OP_INSERT, '0, 6'd21);
      send_op(OP_REMOVE, '0, 6'd2);

      for (int unsigned i = 0; i < RandomOps; i++) begin
         phase        = i / 150;
         insert_share = (phase % 2 == 0) ? 80 : 20;
         no_gaps      = (phase % 5 == 3);
         if (i == 1000) begin
            req_chan_if.valid = 1'b0;
            while (in_flight != 0) @(negedge clock);
         end
         if ($urandom_range(0, 99) < insert_share) begin
            send_op(OP_INSERT, draw_length(), SlotW'($urandom_range(0, MaxSlots - 1)));
         end else begin
            send_op(OP_REMOVE, LenW'($urandom_range(0, PageBytes)),
                    SlotW'($urandom_range(0, MaxSlots - 1)));
         end
      end
      req_chan_if.valid = 1'b0;

      while (in_flight != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("Ran %0d page operations with random gaps, one long response stall and one drain.",
               RandomOps + 17);
      $display("Results: %0d ok, %0d short of space, %0d directory full, %0d empty slot.",
               status_tally[STATUS_OK], status_tally[STATUS_NO_SPACE],
               status_tally[STATUS_DIR_FULL], status_tally[STATUS_EMPTY_SLOT]);
      if (error_count == 0) begin
         $display("slotted_page_space_manager_unit verification clean");
      end else begin
         $display("slotted_page_space_manager_unit verification failed");
      end
      $finish;
   end

endmodule
